[rtl/ckvt_pkg.sv]
// Package with shared constants, codes and types for the compacting key-value table.
`timescale 1ns / 1ps

package ckvt_pkg;

    localparam int DefEntries   = 64;
    localparam int DefKeyBits   = 32;
    localparam int DefValueBits = 32;

    localparam logic [1:0] FUNC_SEARCH = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic cmp;
        logic occupied;
        logic wr;
        logic del;
    } t_cell_ctrl;

endpackage

[rtl/ckvt_cell.sv]
// One table cell holding a key-value pair, its match flag and the chained hit logic.
`timescale 1ns / 1ps

module ckvt_cell
    import ckvt_pkg::*;
#(
    parameter int KEY_BITS   = DefKeyBits,
    parameter int VALUE_BITS = DefValueBits
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctrl            i_ctrl,
    input  logic [KEY_BITS-1:0]   i_cmp_key,
    input  logic [KEY_BITS-1:0]   i_new_key,
    input  logic [VALUE_BITS-1:0] i_new_value,
    input  logic [KEY_BITS-1:0]   i_next_key,
    input  logic [VALUE_BITS-1:0] i_next_value,
    input  logic                  i_hit,
    input  logic [VALUE_BITS-1:0] i_found,
    output logic                  o_hit,
    output logic [VALUE_BITS-1:0] o_found,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value
);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctrl.cmp) begin
            r_match <= i_ctrl.occupied && (r_key == i_cmp_key);
        end
    end

    // A delete pulls every entry at or above the removed one down by one place.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr) begin
            r_key   <= i_new_key;
            r_value <= i_new_value;
        end else if (i_ctrl.del && o_hit) begin
            r_key   <= i_next_key;
            r_value <= i_next_value;
        end
    end

    assign o_hit   = i_hit | r_match;
    assign o_found = i_found | (r_match ? r_value : '0);
    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

[rtl/compacting_key_value_table.sv]
// Top level of the compacting key-value table: request control, entry count and cell row.
//
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+------------------------
//  request  | i_func, i_key, i_value                     | start high, busy low
//  result   | o_status, o_found_value, o_entry_count     | o_done, one cycle, no stall
//
// A request is handled in the cycle it is accepted, where every cell compares
// its key, and then in the busy cycle, where the match ripples along the cell row and the
// insert or the delete shift is written. The result strobe follows in the next cycle,
// together with the next accept. Reset clears the entry count; stored pairs stay
// undefined until written. The receiver cannot stall results.
`timescale 1ns / 1ps

module compacting_key_value_table
    import ckvt_pkg::*;
#(
    parameter int ENTRIES    = DefEntries,
    parameter int KEY_BITS   = DefKeyBits,
    parameter int VALUE_BITS = DefValueBits,
    localparam int CW        = $clog2(ENTRIES + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_func,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output logic [VALUE_BITS-1:0] o_found_value,
    output logic [CW-1:0]         o_entry_count
);

    logic                  r_busy;
    logic [1:0]            r_func;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_done;
    logic [1:0]            r_status;
    logic [1:0]            n_status;
    logic [VALUE_BITS-1:0] r_found;
    logic [VALUE_BITS-1:0] n_found;

    logic                  accept;
    logic                  ins_ok;
    logic                  del_ok;
    logic                  hit;
    logic [VALUE_BITS-1:0] hit_value;

    logic [ENTRIES:0]                 chain_hit;
    logic [ENTRIES:0][VALUE_BITS-1:0] chain_found;
    logic [ENTRIES-1:0][KEY_BITS-1:0]   cell_key;
    logic [ENTRIES-1:0][VALUE_BITS-1:0] cell_value;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    assign chain_hit[0]   = 1'b0;
    assign chain_found[0] = '0;
    assign hit            = chain_hit[ENTRIES];
    assign hit_value      = chain_found[ENTRIES];

    generate
        for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
            t_cell_ctrl            ctrl;
            logic [KEY_BITS-1:0]   next_key;
            logic [VALUE_BITS-1:0] next_value;

            assign ctrl.cmp      = accept;
            assign ctrl.occupied = CW'(g) < r_count;
            assign ctrl.wr       = ins_ok && (r_count == CW'(g));
            assign ctrl.del      = del_ok;

            if (g == ENTRIES - 1) begin : g_last
                assign next_key   = cell_key[g];
                assign next_value = cell_value[g];
            end else begin : g_mid
                assign next_key   = cell_key[g+1];
                assign next_value = cell_value[g+1];
            end

            ckvt_cell #(
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_cmp_key    (i_key),
                .i_new_key    (r_key),
                .i_new_value  (r_value),
                .i_next_key   (next_key),
                .i_next_value (next_value),
                .i_hit        (chain_hit[g]),
                .i_found      (chain_found[g]),
                .o_hit        (chain_hit[g+1]),
                .o_found      (chain_found[g+1]),
                .o_key        (cell_key[g]),
                .o_value      (cell_value[g])
            );
        end
    endgenerate

    always_comb begin
        ins_ok   = 1'b0;
        del_ok   = 1'b0;
        n_status = ST_DONE;
        n_found  = '0;
        n_count  = r_count;
        case (r_func)
            FUNC_INSERT: begin
                if (hit) begin
                    n_status = ST_DUPLICATE;
                end else if (r_count == CW'(ENTRIES)) begin
                    n_status = ST_FULL;
                end else begin
                    ins_ok  = r_busy;
                    n_count = r_count + CW'(1);
                end
            end
            FUNC_DELETE: begin
                // An entry holding a zero value is never removed.
                if (hit && (hit_value != '0)) begin
                    del_ok  = r_busy;
                    n_found = hit_value;
                    n_count = r_count - CW'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                if (hit) begin
                    n_found = hit_value;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= r_busy;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (r_busy) begin
            r_status <= n_status;
            r_found  <= n_found;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_value = r_found;
    assign o_entry_count = r_count;

`ifndef SYNTH
    a_busy_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> o_done)
        else $error("result strobe missing after busy cycle");

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count beyond capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (o_entry_count == CW'(ENTRIES)))
        else $error("full status reported below capacity");
`endif

endmodule
